// ===== rtl/core/mrt_pkg.sv =====
// ----------------------------------------------------------------------------
// mrt_pkg
// shared constants, types and helpers of the motion region tracker
// ----------------------------------------------------------------------------
package mrt_pkg;

	localparam int TABLE_DEPTH = 16;
	localparam int COORD_BITS  = 12;
	localparam int IDX_W       = $clog2(TABLE_DEPTH);
	localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);
	localparam int FRAME_W     = 31;
	localparam int ID_W        = 32;
	localparam int AGE_W       = 16;
	localparam int PROD_W      = 2 * COORD_BITS;
	localparam int IN_BITS     = FRAME_W + 4 * COORD_BITS;
	localparam int IN_DW       = ((IN_BITS + 7) / 8) * 8;
	localparam int OUT_DW      = 48;
	localparam logic [AGE_W-1:0] STALE_AGE_RST = AGE_W'(30);

	typedef enum logic [1:0] {
		FN_DETECT = 2'd0,
		FN_DUP    = 2'd1,
		FN_STALE  = 2'd2,
		FN_NONE   = 2'd3
	} func_t;

	typedef enum logic [1:0] {
		ST_UPDATED  = 2'd0,
		ST_INSERTED = 2'd1,
		ST_DROPPED  = 2'd2,
		ST_PURGED   = 2'd3
	} status_t;

	typedef enum logic [3:0] {
		S_IDLE, S_OV, S_M1, S_M2, S_M3, S_DEC, S_FIN, S_DI, S_DT, S_DW, S_CP, S_DONE
	} state_t;

	typedef struct packed {
		logic [COORD_BITS-1:0] x;
		logic [COORD_BITS-1:0] y;
		logic [COORD_BITS-1:0] w;
		logic [COORD_BITS-1:0] h;
	} box_t;

	function automatic logic [COORD_BITS-1:0] absdiff(input logic [COORD_BITS-1:0] a,
		input logic [COORD_BITS-1:0] b);
		return (a > b) ? a - b : b - a;
	endfunction

	function automatic logic overlap(input box_t a, input box_t b);
		logic [COORD_BITS:0] dx2, dy2, sw, sh;
		dx2 = {absdiff(a.x, b.x), 1'b0};
		dy2 = {absdiff(a.y, b.y), 1'b0};
		sw  = {1'b0, a.w} + {1'b0, b.w};
		sh  = {1'b0, a.h} + {1'b0, b.h};
		return (dx2 < sw) && (dy2 < sh);
	endfunction

endpackage

// ===== rtl/core/motion_region_tracker_top.sv =====
// ----------------------------------------------------------------------------
// motion_region_tracker_top
// table of tracked motion boxes: detection matching, duplicate and stale purge
// ----------------------------------------------------------------------------
// channel   dir  handshake               payload
// s_axis    in   s_axis_tvalid/tready    tuser {first_of_frame, func}, tdata box
// m_axis    out  m_axis_tvalid/tready    tuser status, tdata id/counts
// cfg       in   cfg_valid/cfg_ready     cfg_data stale_age
//
// a detection scans every entry and runs the ratio test on each overlapping one,
// but skips the scan while the frame began empty; func 3 changes no table state
// duplicate purge compares each kept head with the later entries, then compacts
// all ratio products go through the single shared multiplier, one per cycle
// s_axis_tready is low while a request is in work, high again in the same cycle
// as the result is raised; a stalled output holds the next finish
// reset clears the entry count, id counter and frame flag; stale_age returns to 30
module motion_region_tracker_top
	import mrt_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              s_axis_tvalid,
	output logic              s_axis_tready,
	input  logic [2:0]        s_axis_tuser,   // func[1:0], first_of_frame
	input  logic [IN_DW-1:0]  s_axis_tdata,   // frame_number, box_x, box_y, box_w, box_h, pad
	output logic              m_axis_tvalid,
	input  logic              m_axis_tready,
	output logic [1:0]        m_axis_tuser,   // status
	output logic [OUT_DW-1:0] m_axis_tdata,   // region_id, entries_left, removed_count, pad
	input  logic              cfg_valid,
	output logic              cfg_ready,
	input  logic [AGE_W-1:0]  cfg_data
);

	state_t state_q, state_d;

	logic [ID_W-1:0]    ids_q    [TABLE_DEPTH];
	logic [FRAME_W-1:0] frames_q [TABLE_DEPTH];
	box_t               boxes_q  [TABLE_DEPTH];
	logic [1:0]         flags_q  [TABLE_DEPTH];
	logic [TABLE_DEPTH-1:0] keep_q;

	logic [CNT_W-1:0]   cnt_q, i_q, t_q, n_q;
	logic [ID_W-1:0]    next_id_q, rid_q, h_id_q;
	logic               began_q, hit_q;
	logic [1:0]         pend_q;
	logic [AGE_W-1:0]   stale_q;
	func_t              func_q;
	logic [FRAME_W-1:0] fr_q, h_fr_q;
	box_t               box_q, h_box_q;
	status_t            status_q;
	logic [CNT_W-1:0]   removed_q;
	logic [PROD_W:0]    acc_q;
	logic               ovalid_q;
	logic [1:0]         ouser_q;
	logic [OUT_DW-1:0]  odata_q;

	logic [IDX_W-1:0]      rd_idx;
	box_t                  e_box, in_box;
	logic [ID_W-1:0]       e_id;
	logic [FRAME_W-1:0]    e_fr, later_det, later_dup;
	logic                  i_end, t_end, ov_det, ov_dup, stale, keep_now;
	logic [COORD_BITS-1:0] mul_a, mul_b;
	logic [PROD_W-1:0]     mul_p;
	logic [PROD_W+4:0]     num10, den14, den8;
	logic                  is_sub, is_sup, accept, first_in, began_new, out_free;

	mrt_mul u_mul (.clk(clk), .a(mul_a), .b(mul_b), .p_q(mul_p));

	assign accept   = s_axis_tvalid && s_axis_tready;
	assign first_in = s_axis_tuser[2];
	assign in_box   = '{x: s_axis_tdata[FRAME_W +: COORD_BITS],
		y: s_axis_tdata[FRAME_W + COORD_BITS +: COORD_BITS],
		w: s_axis_tdata[FRAME_W + 2*COORD_BITS +: COORD_BITS],
		h: s_axis_tdata[FRAME_W + 3*COORD_BITS +: COORD_BITS]};
	assign began_new = first_in ? (cnt_q == '0) : began_q;
	assign out_free  = !ovalid_q || m_axis_tready;

	assign rd_idx = (state_q == S_DT) ? t_q[IDX_W-1:0] : i_q[IDX_W-1:0];
	assign e_box  = boxes_q[rd_idx];
	assign e_id   = ids_q[rd_idx];
	assign e_fr   = frames_q[rd_idx];
	assign i_end  = i_q >= cnt_q;
	assign t_end  = t_q >= cnt_q;
	assign ov_det = overlap(box_q, e_box);
	assign ov_dup = overlap(h_box_q, e_box);
	assign later_det = (e_fr > fr_q) ? e_fr : fr_q;
	assign later_dup = (e_fr > h_fr_q) ? e_fr : h_fr_q;
	// unsigned age: a stored frame newer than the current one never ages
	assign stale    = (fr_q > e_fr) && ((fr_q - e_fr) > FRAME_W'(stale_q));
	assign keep_now = (func_q == FN_STALE) ? !stale : keep_q[i_q[IDX_W-1:0]];

	// ratio test: num*10 < den*7 with den = 2*ew*eh, num > 4*den
	assign num10  = ((PROD_W+5)'(acc_q) << 3) + ((PROD_W+5)'(acc_q) << 1);
	assign den14  = ((PROD_W+5)'(mul_p) << 3) + ((PROD_W+5)'(mul_p) << 2)
		+ ((PROD_W+5)'(mul_p) << 1);
	assign den8   = (PROD_W+5)'(mul_p) << 3;
	assign is_sub = num10 < den14;
	assign is_sup = (PROD_W+5)'(acc_q) > den8;

	always_comb begin
		mul_a = e_box.w;
		mul_b = e_box.h;
		case (state_q)
			S_M1: begin
				mul_a = box_q.w;
				mul_b = e_box.h;
			end
			S_M2: begin
				mul_a = box_q.h;
				mul_b = e_box.w;
			end
			default: begin
				mul_a = e_box.w;
				mul_b = e_box.h;
			end
		endcase
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			S_IDLE: begin
				if (accept) begin
					case (func_t'(s_axis_tuser[1:0]))
						FN_DETECT: state_d = began_new ? S_FIN : S_OV;
						FN_DUP:    state_d = S_DI;
						FN_STALE:  state_d = S_CP;
						default:   state_d = S_DONE;
					endcase
				end
			end
			S_OV:  if (i_end) state_d = S_FIN; else if (ov_det) state_d = S_M1;
			S_M1:  state_d = S_M2;
			S_M2:  state_d = S_M3;
			S_M3:  state_d = S_DEC;
			S_DEC: state_d = S_OV;
			S_FIN: state_d = S_DONE;
			S_DI: begin
				if (i_end) state_d = S_CP;
				else if (keep_q[i_q[IDX_W-1:0]]) state_d = S_DT;
			end
			S_DT: begin
				if (t_end) state_d = S_DW;
				else if (keep_q[t_q[IDX_W-1:0]] && ov_dup && !(h_id_q < e_id)) state_d = S_DW;
			end
			S_DW:  state_d = S_DI;
			S_CP:  if (i_end) state_d = S_DONE;
			S_DONE: if (out_free) state_d = S_IDLE;
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q     <= '0;
			next_id_q <= '0;
			began_q   <= 1'b0;
			stale_q   <= STALE_AGE_RST;
			ovalid_q  <= 1'b0;
		end else begin
			if (cfg_valid && cfg_ready) stale_q <= cfg_data;
			if (state_q == S_IDLE && accept && func_t'(s_axis_tuser[1:0]) == FN_DETECT)
				began_q <= began_new;
			if (state_q == S_FIN && !(hit_q && pend_q == 2'b00)
				&& cnt_q < CNT_W'(TABLE_DEPTH)) begin
				cnt_q     <= cnt_q + 1'b1;
				next_id_q <= next_id_q + 1'b1;
			end
			if (state_q == S_CP && i_end) cnt_q <= n_q;
			if (m_axis_tvalid && m_axis_tready) ovalid_q <= 1'b0;
			if (state_q == S_DONE && out_free) ovalid_q <= 1'b1;
		end
	end

	// datapath and table
	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				func_q    <= func_t'(s_axis_tuser[1:0]);
				fr_q      <= s_axis_tdata[FRAME_W-1:0];
				box_q     <= in_box;
				i_q       <= '0;
				n_q       <= '0;
				hit_q     <= 1'b0;
				pend_q    <= 2'b00;
				keep_q    <= '1;
				status_q  <= ST_PURGED;
				rid_q     <= '0;
				removed_q <= '0;
			end
			S_OV: if (!i_end && !ov_det) i_q <= i_q + 1'b1;
			S_M2: acc_q <= (PROD_W+1)'(mul_p);
			S_M3: acc_q <= acc_q + (PROD_W+1)'(mul_p);
			S_DEC: begin
				hit_q <= 1'b1;
				if (is_sub) pend_q[0] <= 1'b1;
				else if (is_sup) pend_q[1] <= 1'b1;
				else begin
					boxes_q[rd_idx]  <= box_q;
					flags_q[rd_idx]  <= 2'b00;
					frames_q[rd_idx] <= later_det;
				end
				i_q <= i_q + 1'b1;
			end
			S_FIN: begin
				if (hit_q && pend_q == 2'b00) begin
					status_q <= ST_UPDATED;
				end else if (cnt_q >= CNT_W'(TABLE_DEPTH)) begin
					status_q <= ST_DROPPED;
				end else begin
					status_q <= ST_INSERTED;
					rid_q    <= next_id_q + 1'b1;
					ids_q[cnt_q[IDX_W-1:0]]    <= next_id_q + 1'b1;
					frames_q[cnt_q[IDX_W-1:0]] <= fr_q;
					boxes_q[cnt_q[IDX_W-1:0]]  <= box_q;
					flags_q[cnt_q[IDX_W-1:0]]  <= pend_q;
				end
			end
			S_DI: begin
				if (i_end) begin
					i_q <= '0;
					n_q <= '0;
				end else if (!keep_q[i_q[IDX_W-1:0]]) begin
					i_q <= i_q + 1'b1;
				end else begin
					h_box_q <= e_box;
					h_id_q  <= e_id;
					h_fr_q  <= e_fr;
					t_q     <= i_q + 1'b1;
				end
			end
			S_DT: begin
				if (!t_end) begin
					if (keep_q[t_q[IDX_W-1:0]] && ov_dup) begin
						frames_q[rd_idx] <= later_dup;
						h_fr_q           <= later_dup;
						if (h_id_q < e_id) begin
							keep_q[t_q[IDX_W-1:0]] <= 1'b0;
							t_q <= t_q + 1'b1;
						end else begin
							keep_q[i_q[IDX_W-1:0]] <= 1'b0;
						end
					end else begin
						t_q <= t_q + 1'b1;
					end
				end
			end
			S_DW: begin
				frames_q[i_q[IDX_W-1:0]] <= h_fr_q;
				i_q <= i_q + 1'b1;
			end
			S_CP: begin
				if (i_end) begin
					removed_q <= cnt_q - n_q;
				end else begin
					if (keep_now) begin
						ids_q[n_q[IDX_W-1:0]]    <= e_id;
						frames_q[n_q[IDX_W-1:0]] <= e_fr;
						boxes_q[n_q[IDX_W-1:0]]  <= e_box;
						flags_q[n_q[IDX_W-1:0]]  <= flags_q[rd_idx];
						n_q <= n_q + 1'b1;
					end
					i_q <= i_q + 1'b1;
				end
			end
			S_DONE: begin
				if (out_free) begin
					ouser_q <= status_q;
					odata_q <= {6'b0, 5'(removed_q), 5'(cnt_q), rid_q};
				end
			end
			default: begin
			end
		endcase
	end

	assign s_axis_tready = (state_q == S_IDLE);
	assign cfg_ready     = 1'b1;
	assign m_axis_tvalid = ovalid_q;
	assign m_axis_tuser  = ouser_q;
	assign m_axis_tdata  = odata_q;

	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CNT_W'(TABLE_DEPTH))
		else $error("entry count beyond table depth");

	a_out_from_done: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(ovalid_q) |-> $past(state_q) == S_DONE)
		else $error("result raised outside of finish");

	a_one_request: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> state_q != S_IDLE)
		else $error("request accepted but sequencer stayed idle");

	a_cp_count: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_CP) |-> (n_q <= i_q))
		else $error("compaction write index ahead of read index");

endmodule

// ===== rtl/core/mrt_mul.sv =====
// ----------------------------------------------------------------------------
// mrt_mul
// shared coordinate multiplier with registered product
// ----------------------------------------------------------------------------
module mrt_mul
	import mrt_pkg::*;
(
	input  logic                  clk,
	input  logic [COORD_BITS-1:0] a,
	input  logic [COORD_BITS-1:0] b,
	output logic [PROD_W-1:0]     p_q
);

	always_ff @(posedge clk) begin
		p_q <= PROD_W'(a) * PROD_W'(b);
	end

endmodule
